// ===== rtl/core/cp1251_to_utf8_converter_macros.svh =====
// Assertion macros for the CP1251 to UTF-8 converter checker.
// Stand-alone header; no dependencies.
`ifndef CP1251_TO_UTF8_CONVERTER_MACROS_SVH
`define CP1251_TO_UTF8_CONVERTER_MACROS_SVH

// Concurrent assertion, disabled while reset is asserted
`define C2U_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Concurrent assertion that is also checked during reset
`define C2U_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/core/c2u_pkg.sv =====
// Shared types, constants and the high-half code table of the converter.
// No dependencies.
`default_nettype none

package c2u_pkg;

  // String terminator byte, on input and on output
  localparam logic [7:0] NUL_BYTE = 8'h00;

  // One UTF-8 sequence, first byte in the low bits, with its byte count (0..3)
  typedef struct packed {
    logic [23:0] bytes;
    logic [1:0]  len;
  } seq_t;

  // Entries for source bytes 0x80..0xBF; 0x98 has no mapping
  localparam logic [23:0] HI_MAP_LO [0:63] = '{
    24'h0082D0, 24'h0083D0, 24'h9A80E2, 24'h0093D1,
    24'h9E80E2, 24'hA680E2, 24'hA080E2, 24'hA180E2,
    24'hAC82E2, 24'hB080E2, 24'h0089D0, 24'hB980E2,
    24'h008AD0, 24'h008CD0, 24'h008BD0, 24'h008FD0,
    24'h0092D1, 24'h9880E2, 24'h9980E2, 24'h9C80E2,
    24'h9D80E2, 24'hA280E2, 24'h9380E2, 24'h9480E2,
    24'h000000, 24'hA284E2, 24'h0099D1, 24'hBA80E2,
    24'h009AD1, 24'h009CD1, 24'h009BD1, 24'h009FD1,
    24'h00A0C2, 24'h008ED0, 24'h009ED1, 24'h0088D0,
    24'h00A4C2, 24'h0090D2, 24'h00A6C2, 24'h00A7C2,
    24'h0081D0, 24'h00A9C2, 24'h0084D0, 24'h00ABC2,
    24'h00ACC2, 24'h00ADC2, 24'h00AEC2, 24'h0087D0,
    24'h00B0C2, 24'h00B1C2, 24'h0086D0, 24'h0096D1,
    24'h0091D2, 24'h00B5C2, 24'h00B6C2, 24'h00B7C2,
    24'h0091D1, 24'h9684E2, 24'h0094D1, 24'h00BBC2,
    24'h0098D1, 24'h0085D0, 24'h0095D1, 24'h0097D1
  };

  // Look up the UTF-8 sequence of source byte {1, idx}
  function automatic logic [23:0] hi_map(input logic [6:0] idx);
    logic [23:0] entry;
    if (!idx[6]) begin
      entry = HI_MAP_LO[idx[5:0]];
    end else if (idx[5:4] != 2'b11) begin
      // Cyrillic capitals and first lower-case half: D0 90..D0 BF
      entry = {8'h00, {1'b0, idx} + 8'h50, 8'hD0};
    end else begin
      // Second lower-case half: D1 80..D1 8F
      entry = {8'h00, {1'b0, idx} + 8'h10, 8'hD1};
    end
    return entry;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/c2u_decode.sv =====
// Source byte decode and per-string character count / limit state.
// Depends on c2u_pkg (sequence type, code table).
`default_nettype none

module c2u_decode #(
  parameter int COUNT_BITS = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire logic [7:0]        in_byte_i,
  input  wire logic [15:0]       max_chars_i,
  output c2u_pkg::seq_t          seq_o
);

  localparam int CmpW = (COUNT_BITS > 16) ? COUNT_BITS : 16;

  logic [COUNT_BITS-1:0] count_q, count_d;
  logic                  hit_q, hit_d;
  logic [CmpW-1:0]       count_ext, max_ext;
  logic                  hit_now;
  logic [23:0]           entry;
  c2u_pkg::seq_t         seq;

  assign count_ext = CmpW'(count_q);
  assign max_ext   = CmpW'(max_chars_i);
  assign hit_now   = hit_q || ((max_chars_i != 16'd0) && (count_ext >= max_ext));
  assign entry     = c2u_pkg::hi_map(in_byte_i[6:0]);

  // Map the byte to a sequence and work out the next count state
  always_comb begin
    seq     = '0;
    count_d = count_q;
    hit_d   = hit_q;
    if (in_byte_i == c2u_pkg::NUL_BYTE) begin
      seq.bytes = {16'h0000, c2u_pkg::NUL_BYTE};
      seq.len   = 2'd1;
      count_d   = '0;
      hit_d     = 1'b0;
    end else if (hit_now) begin
      // Drop until the terminator
      hit_d = 1'b1;
    end else begin
      if (!in_byte_i[7]) begin
        seq.bytes = {16'h0000, in_byte_i};
        seq.len   = 2'd1;
      end else if (entry != 24'd0) begin
        seq.bytes = entry;
        seq.len   = (entry[23:16] != 8'd0) ? 2'd3 : 2'd2;
      end
      // Count converted characters, saturating
      if ((seq.len != 2'd0) && (count_q != {COUNT_BITS{1'b1}})) begin
        count_d = count_q + 1'b1;
      end
    end
  end

  // Advance state on each accepted transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      hit_q   <= 1'b0;
    end else if (accept_i) begin
      count_q <= count_d;
      hit_q   <= hit_d;
    end
  end

  assign seq_o = seq;

endmodule

`default_nettype wire

// ===== rtl/core/c2u_serializer.sv =====
// Result register that sends a held UTF-8 sequence one byte per transfer.
// Depends on c2u_pkg (sequence type).
`default_nettype none

module c2u_serializer (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          load_i,
  input  wire c2u_pkg::seq_t seq_i,
  output logic               free_o,
  output logic               tvalid_o,
  input  wire logic          tready_i,
  output logic [7:0]         tdata_o,
  output logic               tlast_o
);

  logic [23:0] bytes_q, bytes_d;
  logic [1:0]  left_q, left_d;
  logic        take;

  assign tvalid_o = (left_q != 2'd0);
  assign tdata_o  = bytes_q[7:0];
  assign tlast_o  = (left_q == 2'd1);
  assign take     = tvalid_o && tready_i;
  // Free when empty or when the final byte leaves this cycle
  assign free_o   = (left_q == 2'd0) || (tlast_o && tready_i);

  // Load a new sequence or shift out the byte just taken
  always_comb begin
    bytes_d = bytes_q;
    left_d  = left_q;
    if (load_i) begin
      bytes_d = seq_i.bytes;
      left_d  = seq_i.len;
    end else if (take) begin
      bytes_d = {8'h00, bytes_q[23:8]};
      left_d  = left_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= 2'd0;
    end else begin
      left_q <= left_d;
    end
  end

  // Hold payload; no reset needed
  always_ff @(posedge clk_i) begin
    bytes_q <= bytes_d;
  end

endmodule

`default_nettype wire

// ===== rtl/core/cp1251_to_utf8_converter.sv =====
// Top level of the Windows-1251 to UTF-8 stream converter.
// Depends on c2u_pkg, c2u_decode and c2u_serializer.
//
//   channel   dir  handshake          payload
//   s_axis    in   tvalid/tready      tdata[7:0] = in_byte
//   m_axis    out  tvalid/tready      tdata[7:0] = out_byte, tlast = last
//   cfg       in   cfg_we_i           cfg_wdata_i[15:0] = max_chars
//
// Results appear in the cycle after the input transfer, one byte per
// cycle while m_axis_tready is high; the output register sets the rate.
// An item stays there until its last byte is taken; ASCII and the
// terminator have one byte, others two or three, dropped items none.
// Reset clears the character count, the limit flag, max_chars and the output.
// s_axis_tready is low while a sequence waits, except when its final byte
// is taken in that cycle.
`default_nettype none

module cp1251_to_utf8_converter #(
  parameter int COUNT_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [7:0] out_byte
  output logic             m_axis_tlast
);

  logic [15:0]   max_chars_q;
  logic          accept;
  logic          free;
  c2u_pkg::seq_t seq;

  // Hold the character limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_chars_q <= 16'd0;
    end else if (cfg_we_i) begin
      max_chars_q <= cfg_wdata_i;
    end
  end

  assign s_axis_tready = free;
  assign accept        = s_axis_tvalid && free;

  c2u_decode #(
    .COUNT_BITS (COUNT_BITS)
  ) u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .in_byte_i   (s_axis_tdata),
    .max_chars_i (max_chars_q),
    .seq_o       (seq)
  );

  c2u_serializer u_serializer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (accept),
    .seq_i    (seq),
    .free_o   (free),
    .tvalid_o (m_axis_tvalid),
    .tready_i (m_axis_tready),
    .tdata_o  (m_axis_tdata),
    .tlast_o  (m_axis_tlast)
  );

endmodule

`default_nettype wire

// ===== rtl/core/c2u_checker.sv =====
// Port-level checker for the converter, bound to the top level.
// Depends on cp1251_to_utf8_converter_macros.svh.
`default_nettype none

`include "cp1251_to_utf8_converter_macros.svh"

module c2u_port_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready,
  input wire logic [7:0] m_axis_tdata,
  input wire logic       m_axis_tlast
);

  // No output in the cycle after reset holds
  `C2U_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |=> !m_axis_tvalid, "output valid in reset")

  // A stalled transfer keeps its payload
  `C2U_ASSERT(a_stall_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled output changed")

  // A zero byte is only ever a terminator, alone in its item
  `C2U_ASSERT(a_nul_last, clk_i, rst_ni, m_axis_tvalid && (m_axis_tdata == 8'h00) |-> m_axis_tlast, "zero byte not last")

  // Bytes before the last of a sequence are multi-byte UTF-8 bytes
  `C2U_ASSERT(a_multi_hi, clk_i, rst_ni, m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[7], "non-last byte below 0x80")

  // A sequence never breaks off: the next byte follows at once
  `C2U_ASSERT(a_seq_cont, clk_i, rst_ni, m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid, "sequence broken off")

endmodule

bind cp1251_to_utf8_converter c2u_port_checker u_c2u_checker (.*);

`default_nettype wire

// ===== verif/c2u_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the CP1251 to UTF-8 stream converter: watches the limit register
// port and both stream channels, predicts each output byte and checks it in order.
// Depends on c2u_pkg for the terminator code.
module c2u_checker #(
  parameter int COUNT_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  input  logic        m_axis_tlast,
  output int          mismatches_o,
  output int          pending_o,
  output int          checked_o
);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } utf8_beat_t;

  // UTF-8 sequences of source bytes 0x80..0xBF, first byte in the low bits
  localparam logic [23:0] CP1251_UPPER [0:63] = '{
    24'h0082D0, 24'h0083D0, 24'h9A80E2, 24'h0093D1,
    24'h9E80E2, 24'hA680E2, 24'hA080E2, 24'hA180E2,
    24'hAC82E2, 24'hB080E2, 24'h0089D0, 24'hB980E2,
    24'h008AD0, 24'h008CD0, 24'h008BD0, 24'h008FD0,
    24'h0092D1, 24'h9880E2, 24'h9980E2, 24'h9C80E2,
    24'h9D80E2, 24'hA280E2, 24'h9380E2, 24'h9480E2,
    24'h000000, 24'hA284E2, 24'h0099D1, 24'hBA80E2,
    24'h009AD1, 24'h009CD1, 24'h009BD1, 24'h009FD1,
    24'h00A0C2, 24'h008ED0, 24'h009ED1, 24'h0088D0,
    24'h00A4C2, 24'h0090D2, 24'h00A6C2, 24'h00A7C2,
    24'h0081D0, 24'h00A9C2, 24'h0084D0, 24'h00ABC2,
    24'h00ACC2, 24'h00ADC2, 24'h00AEC2, 24'h0087D0,
    24'h00B0C2, 24'h00B1C2, 24'h0086D0, 24'h0096D1,
    24'h0091D2, 24'h00B5C2, 24'h00B6C2, 24'h00B7C2,
    24'h0091D1, 24'h9684E2, 24'h0094D1, 24'h00BBC2,
    24'h0098D1, 24'h0085D0, 24'h0095D1, 24'h0097D1
  };

  logic [15:0]           max_chars_q;
  logic [COUNT_BITS-1:0] char_cnt_q;
  logic                  limit_hit_q;
  utf8_beat_t            utf8_q[$];

  // Encode one source byte; returns the byte count, 0 for the unmapped code
  function automatic int unsigned utf8_of_cp1251(input logic [7:0] b,
                                                 output logic [23:0] seq);
    logic [10:0] cp;
    seq = '0;
    if (!b[7]) begin
      seq = {16'h0000, b};
      return 1;
    end
    if (b < 8'hC0) begin
      seq = CP1251_UPPER[b[5:0]];
      if (seq == '0) return 0;
      return (seq[23:16] != 8'h00) ? 3 : 2;
    end
    // Cyrillic letters: code points U+0410..U+044F, two-byte form
    cp = 11'h410 + 11'(b - 8'hC0);
    seq = {8'h00, 2'b10, cp[5:0], 3'b110, cp[10:6]};
    return 2;
  endfunction

  task automatic flag_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatches_o++;
  endtask

  // Queue the output bytes that one accepted source byte should produce
  task automatic convert_byte(input logic [7:0] b);
    logic [23:0] seq;
    int unsigned n;
    if (b == c2u_pkg::NUL_BYTE) begin
      char_cnt_q  = '0;
      limit_hit_q = 1'b0;
      utf8_q.push_back('{data: c2u_pkg::NUL_BYTE, last: 1'b1});
      return;
    end
    if (!limit_hit_q && max_chars_q != 16'd0 &&
        longint'(char_cnt_q) >= longint'(max_chars_q))
      limit_hit_q = 1'b1;
    if (limit_hit_q) return;
    n = utf8_of_cp1251(b, seq);
    if (n == 0) return;
    for (int unsigned k = 0; k < n; k++)
      utf8_q.push_back('{data: seq[8*k +: 8], last: (k == n - 1)});
    // Saturate the character count
    if (char_cnt_q != '1) char_cnt_q = char_cnt_q + 1'b1;
  endtask

  // Check output transfers, predict input transfers, then track the register
  always @(posedge clk_i or negedge rst_ni) begin : scoreboard
    utf8_beat_t want;
    if (!rst_ni) begin
      max_chars_q = '0;
      char_cnt_q  = '0;
      limit_hit_q = 1'b0;
      utf8_q.delete();
      pending_o <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        checked_o <= checked_o + 1;
        if (utf8_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected byte %02h last %0b", m_axis_tdata,
                                  m_axis_tlast));
        end else begin
          want = utf8_q.pop_front();
          if (m_axis_tdata !== want.data)
            flag_mismatch($sformatf("out_byte %02h, want %02h", m_axis_tdata, want.data));
          if (m_axis_tlast !== want.last)
            flag_mismatch($sformatf("last %0b on byte %02h, want %0b", m_axis_tlast,
                                    m_axis_tdata, want.last));
        end
      end
      if (s_axis_tvalid && s_axis_tready) convert_byte(s_axis_tdata);
      if (cfg_we_i) max_chars_q = cfg_wdata_i;
      pending_o <= utf8_q.size();
    end
  end

endmodule

// ===== verif/tb_cp1251_to_utf8_converter.sv =====
`timescale 1ns / 1ps
// Top of the CP1251 to UTF-8 converter testbench: clock, reset, byte stimulus,
// output back-pressure and the verdict. Depends on c2u_pkg and c2u_checker.
module tb_cp1251_to_utf8_converter;

  localparam logic [7:0] UNMAPPED_BYTE = 8'h98;
  localparam int         LONG_HOLD     = 80;
  localparam int         RUN_LIMIT_NS  = 2_000_000;

  // Directed bytes sent with no limit: extremes, table corners, two- and
  // three-byte entries, the unmapped code and terminators
  localparam logic [7:0] OPEN_BYTES [0:15] = '{
    8'h00, 8'h01, 8'h41, 8'h7F, 8'h80, 8'h82, 8'h98, 8'h99,
    8'hAA, 8'hBF, 8'hC0, 8'hEF, 8'hF0, 8'hFF, 8'h55, 8'h00
  };
  // Directed bytes under a limit of two: unmapped code not counted, drops
  // after the limit, terminator clearing the limit
  localparam logic [7:0] LIMIT_BYTES [0:7] = '{
    8'h41, 8'h98, 8'hC0, 8'h42, 8'h98, 8'h00, 8'h43, 8'h00
  };
  localparam logic [15:0] LIMIT_SETS [0:6] = '{
    16'd0, 16'd1, 16'hFFFF, 16'd3, 16'd0, 16'd2, 16'd5
  };

  typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_SPARSE, RX_TOGGLE} rx_mode_e;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [15:0] cfg_wdata_i   = 16'd0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'd0;   // [7:0] in_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;           // [7:0] out_byte
  logic        m_axis_tlast;

  int mismatches;
  int pending;
  int checked;
  int bytes_sent;
  int limit_writes;
  int burst_left;
  int hold_requests;
  int holds_done;

  always #5 clk_i = ~clk_i;

  cp1251_to_utf8_converter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  c2u_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .mismatches_o  (mismatches),
    .pending_o     (pending),
    .checked_o     (checked)
  );

  // Offer one byte, opening a new burst after a random gap when one runs out
  task automatic push_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    burst_left--;
    bytes_sent++;
  endtask

  // Stop offering and hold until every predicted byte has come out
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    // Let a dropped byte still in the pipe settle
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_limit(input logic [15:0] value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    limit_writes++;
  endtask

  // Mostly ASCII and table bytes, now and then the unmapped code
  function automatic logic [7:0] random_char();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 8'($urandom_range(1, 127));
      9:          return UNMAPPED_BYTE;
      default:    return 8'($urandom_range(128, 255));
    endcase
  endfunction

  // Output back-pressure: segments of different stall patterns, plus a long
  // hold whenever the stimulus asks for one
  initial begin : receiver
    int seg_left;
    rx_mode_e mode;
    seg_left = 0;
    mode = RX_OPEN;
    forever begin
      @(posedge clk_i);
      if (holds_done != hold_requests) begin
        m_axis_tready <= 1'b0;
        for (int n = 0; n < LONG_HOLD; n++) @(posedge clk_i);
        holds_done++;
      end
      if (seg_left == 0) begin
        mode = rx_mode_e'($urandom_range(0, 3));
        seg_left = $urandom_range(8, 40);
      end
      seg_left--;
      case (mode)
        RX_OPEN:   m_axis_tready <= 1'b1;
        RX_RANDOM: m_axis_tready <= 1'($urandom_range(0, 1));
        RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
        RX_TOGGLE: m_axis_tready <= ~m_axis_tready;
        default:   m_axis_tready <= 1'b1;
      endcase
    end
  end

  initial begin : stimulus
    int phase_bytes;
    int len;
    logic [15:0] limit;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (OPEN_BYTES[i]) push_byte(OPEN_BYTES[i]);
    set_limit(16'd2);
    foreach (LIMIT_BYTES[i]) push_byte(LIMIT_BYTES[i]);

    // Random strings under a sequence of limits
    for (int k = 0; k < 8; k++) begin
      limit = (k < 7) ? LIMIT_SETS[k] : 16'($urandom_range(4, 20));
      set_limit(limit);
      if (k == 1 || k == 5) hold_requests++;
      phase_bytes = 0;
      while (phase_bytes < 45) begin
        if ($urandom_range(0, 9) == 0) begin
          // Noise: any byte, terminators included, strings left open
          len = $urandom_range(1, 4);
          for (int j = 0; j < len; j++) push_byte(8'($urandom_range(0, 255)));
          phase_bytes += len;
        end else begin
          len = $urandom_range(0, 10);
          for (int j = 0; j < len; j++) push_byte(random_char());
          push_byte(c2u_pkg::NUL_BYTE);
          phase_bytes += len + 1;
        end
      end
    end

    drain();
    repeat (10) @(posedge clk_i);
    $display("Sent %0d source bytes under %0d limit settings (none, 1, 65535, small).",
             bytes_sent, limit_writes + 1);
    $display("Checked %0d UTF-8 output bytes with random bursts and back-pressure.",
             checked);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("Timeout with %0d bytes outstanding", pending);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
